// ----- rtl/core/lzwc_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the LZW byte compressor.
// No dependencies; every other file uses it through scoped names.
package lzwc_pkg;

  localparam int CODE_BITS     = 9;
  localparam int DICT_CODES    = 512;
  localparam int BYTE_BITS     = 8;
  localparam int FIRST_LEARNED = 256;
  localparam int STORE_DEPTH   = DICT_CODES - FIRST_LEARNED;
  localparam int IDX_BITS      = $clog2(STORE_DEPTH);
  localparam int USED_BITS     = $clog2(STORE_DEPTH + 1);
  localparam int NFC_BITS      = $clog2(DICT_CODES + 1);
  localparam int ENTRY_BITS    = CODE_BITS + BYTE_BITS;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR   = $clog2(OQ_DEPTH);
  localparam int OQ_CNT   = $clog2(OQ_DEPTH + 1);

  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic [BYTE_BITS-1:0] byte_t;

  typedef struct packed {
    code_t prefix;
    byte_t last_byte;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

endpackage

// ----- rtl/core/lzwc_byte_if.sv -----
`timescale 1ns / 1ps
// Input channel: one uncompressed byte per item plus end-of-stream flag.
// Depends on lzwc_pkg.
interface lzwc_byte_if;
  logic            valid;
  logic            ready;
  lzwc_pkg::byte_t in_byte;
  logic            in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- rtl/core/lzwc_code_if.sv -----
`timescale 1ns / 1ps
// Output channel: one LZW code per item plus final-code flag.
// Depends on lzwc_pkg.
interface lzwc_code_if;
  logic            valid;
  logic            ready;
  lzwc_pkg::code_t code;
  logic            out_last;

  modport source (output valid, output code, output out_last, input ready);
  modport sink   (input valid, input code, input out_last, output ready);
endinterface

// ----- rtl/core/lzw_byte_compressor_unit.sv -----
`timescale 1ns / 1ps
// LZW compressor top level: dictionary memory, match state and output queue.
// Depends on lzwc_pkg, lzwc_byte_if, lzwc_code_if.
//
// One byte is taken at a time. The dictionary of learned (prefix, byte) pairs
// sits in a single-port synchronous RAM indexed by code minus 256, and a lookup
// walks the learned entries in order, one read per cycle, stopping at the first
// hit. Each byte is accepted, then compared in the scan against the learned
// entries, whose number (used) is the count of pairs learned so far in the
// current stream (0 to 256), then committed: state is updated and codes queued.
// A byte that finds no open match, or no learned pair yet, skips the scan.
// Codes leave through a 4-deep output queue, so a slow consumer only stalls
// the block once the queue cannot take two more codes. The last byte of a
// stream flushes the final match with out_last set and empties the dictionary
// at once (the next free code drops back to 256), so no clearing pass is ever
// needed. When all 512 codes are used the dictionary stops growing and
// matching goes on.
module lzw_byte_compressor_unit (
  input  logic               clk,
  input  logic               rst,
  lzwc_byte_if.sink          byte_stream,
  lzwc_code_if.source        code_stream
);

  // ---------------- control and match state ----------------
  lzwc_pkg::state_t                      state, state_next;
  logic [lzwc_pkg::NFC_BITS-1:0]         nfc, nfc_next;       // next free code
  lzwc_pkg::code_t                       match_code, match_code_next;
  logic                                  have_match, have_match_next;

  // current item
  lzwc_pkg::byte_t                       cur_byte;
  logic                                  cur_last;

  // scan bookkeeping
  logic [lzwc_pkg::USED_BITS-1:0]        issue_k, issue_k_next;
  logic                                  rd_pending, rd_pending_next;
  logic [lzwc_pkg::IDX_BITS-1:0]         rd_k;
  logic                                  found, found_next;
  lzwc_pkg::code_t                       found_code, found_code_next;

  logic [lzwc_pkg::USED_BITS-1:0]        used;
  logic                                  hit_now;
  logic                                  rd_en;

  // ---------------- dictionary RAM ----------------
  lzwc_pkg::entry_t                      dict_mem [lzwc_pkg::STORE_DEPTH];
  lzwc_pkg::entry_t                      dict_q;
  logic                                  wr_en;
  logic [lzwc_pkg::IDX_BITS-1:0]         wr_addr;
  lzwc_pkg::entry_t                      wr_data;

  // ---------------- output queue ----------------
  lzwc_pkg::code_t                       oq_code [lzwc_pkg::OQ_DEPTH];
  logic                                  oq_last [lzwc_pkg::OQ_DEPTH];
  logic [lzwc_pkg::OQ_PTR-1:0]           oq_head, oq_tail;
  logic [lzwc_pkg::OQ_CNT-1:0]           oq_cnt;
  logic                                  oq_pop;
  logic                                  push0, push1;
  lzwc_pkg::code_t                       push0_code, push1_code;
  logic                                  push0_last, push1_last;
  logic                                  commit_go;

  assign used = lzwc_pkg::USED_BITS'(nfc - lzwc_pkg::NFC_BITS'(lzwc_pkg::FIRST_LEARNED));

  assign byte_stream.ready = (state == lzwc_pkg::ST_IDLE);

  // compare of the entry read last cycle
  assign hit_now = (state == lzwc_pkg::ST_SCAN) && rd_pending &&
                   (dict_q.prefix == match_code) && (dict_q.last_byte == cur_byte);

  assign rd_en = (state == lzwc_pkg::ST_SCAN) && (issue_k < used) && !hit_now;

  // queue must have room for two codes before state is committed
  assign commit_go = (state == lzwc_pkg::ST_COMMIT) &&
                     (oq_cnt <= lzwc_pkg::OQ_CNT'(lzwc_pkg::OQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rd_en) begin
      dict_q <= dict_mem[issue_k[lzwc_pkg::IDX_BITS-1:0]];
    end
    if (wr_en) begin
      dict_mem[wr_addr] <= wr_data;
    end
  end

  // ---------------- next-state logic ----------------
  always_comb begin
    lzwc_pkg::code_t m;
    state_next      = state;
    nfc_next        = nfc;
    match_code_next = match_code;
    have_match_next = have_match;
    issue_k_next    = issue_k;
    rd_pending_next = rd_en;
    found_next      = found;
    found_code_next = found_code;
    wr_en           = 1'b0;
    wr_addr         = used[lzwc_pkg::IDX_BITS-1:0];
    wr_data         = '{prefix: match_code, last_byte: cur_byte};
    push0           = 1'b0;
    push1           = 1'b0;
    push0_code      = match_code;
    push0_last      = 1'b0;
    push1_code      = match_code;
    push1_last      = 1'b1;
    m               = match_code;

    case (state)
      lzwc_pkg::ST_IDLE: begin
        if (byte_stream.valid) begin
          found_next   = 1'b0;
          issue_k_next = '0;
          if (have_match && (used != '0)) begin
            state_next = lzwc_pkg::ST_SCAN;
          end else begin
            state_next = lzwc_pkg::ST_COMMIT;
          end
        end
      end

      lzwc_pkg::ST_SCAN: begin
        if (rd_en) begin
          issue_k_next = issue_k + 1'b1;
        end
        if (hit_now) begin
          found_next      = 1'b1;
          found_code_next = lzwc_pkg::CODE_BITS'(lzwc_pkg::FIRST_LEARNED)
                            + lzwc_pkg::CODE_BITS'(rd_k);
          rd_pending_next = 1'b0;
          state_next      = lzwc_pkg::ST_COMMIT;
        end else if (!rd_pending && (issue_k == used)) begin
          state_next = lzwc_pkg::ST_COMMIT;   // walked every entry, no hit
        end
      end

      lzwc_pkg::ST_COMMIT: begin
        if (commit_go) begin
          if (!have_match) begin
            m = lzwc_pkg::CODE_BITS'(cur_byte);   // stream opens with this byte
          end else if (found) begin
            m = found_code;
          end else begin
            push0      = 1'b1;
            push0_code = match_code;
            if (nfc < lzwc_pkg::NFC_BITS'(lzwc_pkg::DICT_CODES)) begin
              wr_en    = 1'b1;
              nfc_next = nfc + 1'b1;
            end
            m = lzwc_pkg::CODE_BITS'(cur_byte);
          end
          if (cur_last) begin
            push1           = 1'b1;
            push1_code      = m;
            have_match_next = 1'b0;
            match_code_next = '0;
            nfc_next        = lzwc_pkg::NFC_BITS'(lzwc_pkg::FIRST_LEARNED);
          end else begin
            have_match_next = 1'b1;
            match_code_next = m;
          end
          state_next = lzwc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = lzwc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lzwc_pkg::ST_IDLE;
      nfc        <= lzwc_pkg::NFC_BITS'(lzwc_pkg::FIRST_LEARNED);
      match_code <= '0;
      have_match <= 1'b0;
      rd_pending <= 1'b0;
      found      <= 1'b0;
      issue_k    <= '0;
    end else begin
      state      <= state_next;
      nfc        <= nfc_next;
      match_code <= match_code_next;
      have_match <= have_match_next;
      rd_pending <= rd_pending_next;
      found      <= found_next;
      issue_k    <= issue_k_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (byte_stream.valid && byte_stream.ready) begin
      cur_byte <= byte_stream.in_byte;
      cur_last <= byte_stream.in_last;
    end
    if (rd_en) begin
      rd_k <= issue_k[lzwc_pkg::IDX_BITS-1:0];
    end
    found_code <= found_code_next;
  end

  // ---------------- output queue ----------------
  assign code_stream.valid    = (oq_cnt != '0);
  assign code_stream.code     = oq_code[oq_head];
  assign code_stream.out_last = oq_last[oq_head];
  assign oq_pop = code_stream.valid && code_stream.ready;

  always_ff @(posedge clk) begin
    logic [lzwc_pkg::OQ_PTR-1:0] t;
    t = oq_tail;
    if (push0) begin
      oq_code[t] <= push0_code;
      oq_last[t] <= push0_last;
      t = t + 1'b1;
    end
    if (push1) begin
      oq_code[t] <= push1_code;
      oq_last[t] <= push1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_head <= '0;
      oq_tail <= '0;
      oq_cnt  <= '0;
    end else begin
      oq_tail <= oq_tail + lzwc_pkg::OQ_PTR'(push0) + lzwc_pkg::OQ_PTR'(push1);
      if (oq_pop) begin
        oq_head <= oq_head + 1'b1;
      end
      oq_cnt <= oq_cnt + lzwc_pkg::OQ_CNT'(push0) + lzwc_pkg::OQ_CNT'(push1)
                - lzwc_pkg::OQ_CNT'(oq_pop);
    end
  end

endmodule
